[hw/rtl/tsd_pkg.sv]
// Package for the Taylor sigmoid and derivative unit.
// Holds field widths, fixed-point constants and pipeline depths.
// No dependencies.
package tsd_pkg;

	localparam int XW = 16;
	localparam int YW = 16;
	localparam int UW = 16;
	localparam int SQW = 2 * UW;
	localparam int DW = 31;
	localparam int QW = YW + 1;
	localparam int DivSteps = QW;
	localparam int PW = 2 * QW;

	localparam logic [DW-1:0] OneQ25 = DW'(32'h0200_0000);
	localparam logic [DW-1:0] TwoQ25 = DW'(32'h0400_0000);
	localparam int FracShift = 13;
	localparam logic [QW-1:0] OneQ16 = QW'(32'h0001_0000);
	localparam logic [PW-1:0] HalfLsb = PW'(32'h0000_8000);
	localparam logic [YW-1:0] YMax = '1;
	localparam int Latency = 3 + DivSteps + 3;

endpackage

[hw/rtl/taylor_sigmoid_and_derivative.sv]
// Sigmoid and sigmoid-derivative unit built on a second-order Taylor exponential.
// Top level; uses tsd_pkg for widths and constants.
//
// Usage: a request carries x_value (signed Q4.12) and action (0 for the sigmoid,
// 1 for s*(1-s)). It is taken at a rising edge where in_valid is high and
// in_stall is low. The result y_value (unsigned Q0.16, 1.0 reads 65535) is
// offered with y_valid and taken at an edge where y_stall is low.
// From acceptance to y_valid a request passes registers for the magnitude, square
// and denominator, the restoring divider (one quotient bit per stage), then rounding,
// the derivative product and the output register. Throughput is one request per
// cycle while the output is not stalled.
// The whole pipeline advances together; it holds only while the output register
// carries a result that the receiver stalls, and then in_stall is high.
// Reset clears every valid bit, so no result is shown after reset until a new
// request has passed through the pipeline.
module taylor_sigmoid_and_derivative (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [tsd_pkg::XW-1:0]  x_value,
	input  logic                    action,
	output logic                    y_valid,
	input  logic                    y_stall,
	output logic [tsd_pkg::YW-1:0]  y_value
);

	logic en;
	logic take;

	logic                   v_s1, v_s2;
	logic [tsd_pkg::UW-1:0] u_s1, u_s2;
	logic                   pos_s1, pos_s2;
	logic                   act_s1, act_s2;
	logic [tsd_pkg::SQW-1:0] sq_s2;

	logic                   v_s  [0:tsd_pkg::DivSteps];
	logic                   act_s[0:tsd_pkg::DivSteps];
	logic [tsd_pkg::DW-1:0] d_s  [0:tsd_pkg::DivSteps];
	logic [tsd_pkg::DW-1:0] rem_s[0:tsd_pkg::DivSteps];
	logic [tsd_pkg::QW-1:0] q_s  [0:tsd_pkg::DivSteps];

	logic                   v_rs, act_rs;
	logic [tsd_pkg::QW-1:0] s_rs;
	logic                   v_ms, act_ms;
	logic [tsd_pkg::QW-1:0] s_ms;
	logic [tsd_pkg::PW-1:0] p_ms;

	logic [tsd_pkg::UW-1:0] u_in;
	logic [tsd_pkg::DW-1:0] a_fix;
	logic [tsd_pkg::DW-1:0] d_fix;
	logic [tsd_pkg::PW-1:0] p_round;
	logic [tsd_pkg::PW-1:0] deriv;
	logic [tsd_pkg::YW-1:0] y_next;

	assign en = !(y_valid && y_stall);
	assign in_stall = !en;
	assign take = in_valid && en;

	assign u_in = x_value[tsd_pkg::XW-1] ? tsd_pkg::UW'(~x_value + 1'b1)
		: tsd_pkg::UW'(x_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= u_in;
			pos_s1 <= !x_value[tsd_pkg::XW-1] && (x_value != '0);
			act_s1 <= action;
			u_s2   <= u_s1;
			pos_s2 <= pos_s1;
			act_s2 <= act_s1;
			sq_s2  <= u_s1 * u_s1;
		end
	end

	assign a_fix = tsd_pkg::OneQ25 + (tsd_pkg::DW'(u_s2) << tsd_pkg::FracShift)
		+ tsd_pkg::DW'(sq_s2);
	assign d_fix = a_fix + tsd_pkg::OneQ25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s[0] <= act_s2;
			d_s[0]   <= d_fix;
			rem_s[0] <= pos_s2 ? a_fix : tsd_pkg::OneQ25;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < tsd_pkg::DivSteps; k++) begin : g_div
		logic [tsd_pkg::DW:0] r2;
		logic                 ge;

		assign r2 = {rem_s[k], 1'b0};
		assign ge = r2 >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				act_s[k+1] <= act_s[k];
				d_s[k+1]   <= d_s[k];
				rem_s[k+1] <= ge ? tsd_pkg::DW'(r2 - {1'b0, d_s[k]}) : tsd_pkg::DW'(r2);
				q_s[k+1]   <= {q_s[k][tsd_pkg::QW-2:0], ge};
			end
		end
	end

	assign p_round = p_ms + tsd_pkg::HalfLsb;
	assign deriv = p_round >> tsd_pkg::YW;

	always_comb begin
		if (act_ms) begin
			y_next = (deriv > tsd_pkg::PW'(tsd_pkg::YMax)) ? tsd_pkg::YMax
				: tsd_pkg::YW'(deriv);
		end else begin
			y_next = (s_ms > tsd_pkg::QW'(tsd_pkg::YMax)) ? tsd_pkg::YMax
				: tsd_pkg::YW'(s_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rs    <= 1'b0;
			v_ms    <= 1'b0;
			y_valid <= 1'b0;
		end else if (en) begin
			v_rs    <= v_s[tsd_pkg::DivSteps];
			v_ms    <= v_rs;
			y_valid <= v_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_rs  <= act_s[tsd_pkg::DivSteps];
			s_rs    <= tsd_pkg::QW'(q_s[tsd_pkg::DivSteps] >> 1)
				+ tsd_pkg::QW'(q_s[tsd_pkg::DivSteps][0]);
			act_ms  <= act_rs;
			s_ms    <= s_rs;
			p_ms    <= s_rs * (tsd_pkg::OneQ16 - s_rs);
			y_value <= y_next;
		end
	end

endmodule

[hw/rtl/tsd_checker.sv]
// Port-level checker for the Taylor sigmoid and derivative unit.
// Uses tsd_pkg for the result width; bound to the top level below.
module tsd_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   y_valid,
	input logic                   y_stall,
	input logic [tsd_pkg::YW-1:0] y_value
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !y_valid)
		else $error("Result shown during reset.");

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (y_valid && y_stall))
		else $error("Input stall does not follow the blocked output.");

	a_drop_only_when_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(y_valid) |-> $past(!y_stall))
		else $error("Result withdrawn without being taken.");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		y_valid && y_stall |=> y_valid && $stable(y_value))
		else $error("Stalled result changed.");

endmodule

bind taylor_sigmoid_and_derivative tsd_checker u_tsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_stall (in_stall),
	.y_valid  (y_valid),
	.y_stall  (y_stall),
	.y_value  (y_value)
);
